// File: sv/ale_pkg.sv
// ============================================================================
// ale_pkg: shared types and constants for the array list engine
// Operation codes, status codes, sequencer states and stream field widths.
// ============================================================================
`default_nettype none

package ale_pkg;

    localparam int OPC_W   = 4;
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int VALUE_W = 38;
    localparam int INDEX_W = 7;
    localparam int LEN_W   = 7;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 56;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT  = 4'd0,
        OP_DELETE  = 4'd1,
        OP_GET     = 4'd2,
        OP_SET     = 4'd3,
        OP_LSEARCH = 4'd4,
        OP_BSEARCH = 4'd5,
        OP_MAX     = 4'd6,
        OP_MIN     = 4'd7,
        OP_SUM     = 4'd8,
        OP_AVG     = 4'd9,
        OP_REVERSE = 4'd10,
        OP_LSHIFT  = 4'd11,
        OP_RSHIFT  = 4'd12,
        OP_LROT    = 4'd13,
        OP_RROT    = 4'd14,
        OP_NOP     = 4'd15
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GET,
        ST_LOAD,
        ST_LOADW,
        ST_WALK,
        ST_TAIL,
        ST_REV_A,
        ST_REV_B,
        ST_REV_C,
        ST_REV_D,
        ST_BS_RD,
        ST_BS_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: sv/array_list_engine.sv
// ============================================================================
// array_list_engine: dense list of signed words with one operation per item
// Sequencer over a single-port-read, single-port-write element memory.
// ============================================================================
// One transaction in, one result out. The block takes an item only when its
// sequencer is idle and walks the element memory one word per cycle through
// its single read port for insert, delete, shifts, rotates, linear search,
// max, min, sum and average; reverse swaps one pair at a time, binary search
// reads one probe at a time, and average then runs the bit-serial divider. A
// finished result waits in the output register while the next item is taken.
`default_nettype none

module array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode[3:0], position[9:4], operand_word[41:10], zero[47:42]
    input  wire logic [ale_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // result_value[37:0], found_index[44:38], list_length[51:45],
    // status[53:52], zero[55:54]
    output logic [ale_pkg::OUT_W-1:0]      m_axis_tdata
);

    import ale_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = (CW > POS_W) ? CW : POS_W;
    localparam int ACC_W = WORD_W + AW + 1;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    status_t           status_reg, status_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     waddr_reg, waddr_next;
    logic              up_reg, up_next;
    logic              wr_reg, wr_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] save_reg, save_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    logic              first_reg, first_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [INDEX_W-1:0] found_reg, found_next;
    logic signed [CW:0] lo_reg, lo_next;
    logic signed [CW:0] hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [AW-1:0]     rev_i_reg, rev_i_next;
    logic [AW-1:0]     rev_j_reg, rev_j_next;
    logic [CW-1:0]     pairs_reg, pairs_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [INDEX_W-1:0] out_found_reg;
    logic [LEN_W-1:0]   out_len_reg;
    status_t            out_status_reg;

    op_t               in_op;
    logic [POS_W-1:0]  in_pos;
    logic [WORD_W-1:0] in_word;
    logic              s_fire;
    logic              out_free;
    logic              needs_item;
    logic              needs_index;
    logic [IW-1:0]     pos_w;
    logic [IW-1:0]     n_w;
    logic [IW-1:0]     ins_p;

    state_t            dec_state;
    status_t           dec_status;
    logic [CW-1:0]     dec_steps;
    logic [AW-1:0]     dec_idx;
    logic              dec_up;
    logic              dec_wr;
    logic [AW-1:0]     dec_tail;
    logic [CW-1:0]     dec_count;

    logic [CW:0]       bs_sum;
    logic signed [ACC_W-1:0] d_ext;
    logic              walk_end;
    logic              hit;
    state_t            after_walk;
    logic [WORD_W-1:0] tail_data;
    logic              div_start;
    logic              div_done;
    logic [ACC_W-1:0]  div_mag;
    logic [ACC_W-1:0]  div_quo;
    logic signed [63:0] acc_wide;

    assign in_op   = op_t'(s_axis_tdata[3:0]);
    assign in_pos  = s_axis_tdata[9:4];
    assign in_word = s_axis_tdata[41:10];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign needs_item  = (in_op inside {OP_DELETE, OP_GET, OP_SET, OP_MAX, OP_MIN, OP_AVG});
    assign needs_index = (in_op inside {OP_DELETE, OP_GET, OP_SET});
    assign pos_w       = IW'(in_pos);
    assign n_w         = IW'(count_reg);
    assign ins_p       = (pos_w > n_w) ? n_w : pos_w;

    // Plan the work for an incoming item
    always_comb
    begin
        dec_state  = ST_DONE;
        dec_status = STAT_OK;
        dec_steps  = '0;
        dec_idx    = '0;
        dec_up     = 1'b1;
        dec_wr     = 1'b0;
        dec_tail   = '0;
        dec_count  = count_reg;
        if (needs_item && count_reg == '0)
        begin
            dec_status = STAT_EMPTY;
        end
        else if (needs_index && pos_w >= n_w)
        begin
            dec_status = STAT_BAD_INDEX;
        end
        else
        begin
            unique case (in_op) inside
                OP_INSERT:
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        dec_status = STAT_FULL;
                    end
                    else
                    begin
                        dec_state = ST_WALK;
                        dec_steps = CW'(n_w - ins_p);
                        dec_idx   = AW'(count_reg) - AW'(1);
                        dec_up    = 1'b0;
                        dec_wr    = 1'b1;
                        dec_tail  = AW'(ins_p);
                        dec_count = count_reg + CW'(1);
                    end
                end
                OP_DELETE:
                begin
                    dec_state = ST_WALK;
                    dec_steps = CW'(n_w - pos_w - IW'(1));
                    dec_idx   = AW'(in_pos) + AW'(1);
                    dec_wr    = 1'b1;
                    dec_count = count_reg - CW'(1);
                end
                OP_GET:
                begin
                    dec_state = ST_GET;
                end
                OP_SET:
                begin
                    dec_state = ST_TAIL;
                    dec_tail  = AW'(in_pos);
                end
                OP_LSEARCH, OP_MAX, OP_MIN, OP_SUM, OP_AVG:
                begin
                    dec_state = ST_WALK;
                    dec_steps = count_reg;
                end
                OP_BSEARCH:
                begin
                    dec_state = ST_BS_RD;
                end
                OP_REVERSE:
                begin
                    if (count_reg > CW'(1))
                    begin
                        dec_state = ST_REV_A;
                    end
                end
                OP_LSHIFT, OP_LROT:
                begin
                    if (count_reg != '0)
                    begin
                        dec_state = ST_LOAD;
                        dec_steps = count_reg - CW'(1);
                        dec_idx   = AW'(1);
                        dec_wr    = 1'b1;
                        dec_tail  = AW'(count_reg - CW'(1));
                    end
                end
                OP_RSHIFT, OP_RROT:
                begin
                    if (count_reg != '0)
                    begin
                        dec_state = ST_LOAD;
                        dec_steps = count_reg - CW'(1);
                        dec_idx   = AW'(count_reg - CW'(2));
                        dec_up    = 1'b0;
                        dec_wr    = 1'b1;
                    end
                end
                default:
                begin
                    dec_state = ST_DONE;
                end
            endcase
        end
    end

    assign bs_sum   = (CW+1)'(lo_reg) + (CW+1)'(hi_reg);
    assign d_ext    = ACC_W'($signed(rd_data_reg));
    assign walk_end = (steps_reg == '0) && !pend_reg;
    assign hit      = pend_reg && (op_reg == OP_LSEARCH) && (rd_data_reg == key_reg);

    always_comb
    begin
        unique case (op_reg) inside
            OP_INSERT, OP_LSHIFT, OP_RSHIFT, OP_LROT, OP_RROT: after_walk = ST_TAIL;
            OP_AVG:                                          after_walk = ST_DIV_GO;
            default:                                         after_walk = ST_DONE;
        endcase
    end

    always_comb
    begin
        unique case (op_reg) inside
            OP_INSERT, OP_SET: tail_data = key_reg;
            OP_LROT, OP_RROT:  tail_data = save_reg;
            default:           tail_data = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_fire) state_next = dec_state;
            ST_GET:      state_next = ST_DONE;
            ST_LOAD:     state_next = ST_LOADW;
            ST_LOADW:    state_next = ST_WALK;
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_DONE;
                end
                else if (walk_end)
                begin
                    state_next = after_walk;
                end
            end
            ST_TAIL:     state_next = ST_DONE;
            ST_REV_A:    state_next = ST_REV_B;
            ST_REV_B:    state_next = ST_REV_C;
            ST_REV_C:    state_next = ST_REV_D;
            ST_REV_D:    state_next = (pairs_reg == CW'(1)) ? ST_DONE : ST_REV_A;
            ST_BS_RD:    state_next = (lo_reg > hi_reg) ? ST_DONE : ST_BS_CMP;
            ST_BS_CMP:
            begin
                state_next = (rd_data_reg == key_reg) ? ST_DONE : ST_BS_RD;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory ports
    always_comb
    begin
        mem_raddr = idx_reg;
        mem_we    = 1'b0;
        mem_waddr = waddr_reg;
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:  mem_raddr = AW'(in_pos);
            ST_LOAD:  mem_raddr = up_reg ? '0 : AW'(count_reg - CW'(1));
            ST_WALK:  mem_we    = pend_reg && wr_reg;
            ST_TAIL:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                mem_wdata = tail_data;
            end
            ST_REV_A: mem_raddr = rev_i_reg;
            ST_REV_B: mem_raddr = rev_j_reg;
            ST_REV_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev_i_reg;
            end
            ST_REV_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev_j_reg;
                mem_wdata = tmp_reg;
            end
            ST_BS_RD: mem_raddr = AW'(bs_sum[CW:1]);
            default:  mem_raddr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign div_start = (state_reg == ST_DIV_GO);
    assign div_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    ale_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Datapath
    always_comb
    begin
        op_next     = op_reg;
        status_next = status_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        pend_next   = 1'b0;
        waddr_next  = waddr_reg;
        up_next     = up_reg;
        wr_next     = wr_reg;
        tail_next   = tail_reg;
        key_next    = key_reg;
        save_next   = save_reg;
        tmp_next    = tmp_reg;
        first_next  = first_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        rev_i_next  = rev_i_reg;
        rev_j_next  = rev_j_reg;
        pairs_next  = pairs_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next     = in_op;
                    key_next    = in_word;
                    status_next = dec_status;
                    count_next  = dec_count;
                    steps_next  = dec_steps;
                    idx_next    = dec_idx;
                    up_next     = dec_up;
                    wr_next     = dec_wr;
                    tail_next   = dec_tail;
                    first_next  = 1'b1;
                    acc_next    = '0;
                    found_next  = '1;
                    lo_next     = '0;
                    hi_next     = $signed({1'b0, count_reg}) - (CW+1)'(1);
                    rev_i_next  = '0;
                    rev_j_next  = AW'(count_reg - CW'(1));
                    pairs_next  = count_reg >> 1;
                end
            end
            ST_GET:
            begin
                acc_next = d_ext;
            end
            ST_LOADW:
            begin
                save_next = rd_data_reg;
            end
            ST_WALK:
            begin
                if (pend_reg)
                begin
                    unique case (op_reg) inside
                        OP_LSEARCH:
                        begin
                            if (hit)
                            begin
                                found_next = INDEX_W'(waddr_reg);
                            end
                        end
                        OP_MAX:
                        begin
                            if (first_reg || d_ext > acc_reg) acc_next = d_ext;
                        end
                        OP_MIN:
                        begin
                            if (first_reg || d_ext < acc_reg) acc_next = d_ext;
                        end
                        OP_SUM, OP_AVG:
                        begin
                            acc_next = acc_reg + d_ext;
                        end
                        default:
                        begin
                            acc_next = acc_reg;
                        end
                    endcase
                    first_next = 1'b0;
                end
                if (hit)
                begin
                    steps_next = '0;
                end
                else if (steps_reg != '0)
                begin
                    pend_next  = 1'b1;
                    steps_next = steps_reg - CW'(1);
                    if (!up_reg)
                    begin
                        waddr_next = idx_reg + AW'(1);
                        idx_next   = idx_reg - AW'(1);
                    end
                    else
                    begin
                        waddr_next = wr_reg ? idx_reg - AW'(1) : idx_reg;
                        idx_next   = idx_reg + AW'(1);
                    end
                end
            end
            ST_REV_B:
            begin
                tmp_next = rd_data_reg;
            end
            ST_REV_D:
            begin
                rev_i_next = rev_i_reg + AW'(1);
                rev_j_next = rev_j_reg - AW'(1);
                pairs_next = pairs_reg - CW'(1);
            end
            ST_BS_RD:
            begin
                mid_next = bs_sum[CW:1];
            end
            ST_BS_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    found_next = INDEX_W'(mid_reg);
                end
                else if ($signed(key_reg) > $signed(rd_data_reg))
                begin
                    lo_next = $signed({1'b0, mid_reg}) + (CW+1)'(1);
                end
                else
                begin
                    hi_next = $signed({1'b0, mid_reg}) - (CW+1)'(1);
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    acc_next = acc_reg[ACC_W-1] ? -$signed(div_quo) : $signed(div_quo);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign acc_wide       = 64'(acc_reg);
    assign out_valid_next = ((state_reg == ST_DONE) && out_free) ? 1'b1
                          : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        waddr_reg  <= waddr_next;
        up_reg     <= up_next;
        wr_reg     <= wr_next;
        tail_reg   <= tail_next;
        key_reg    <= key_next;
        save_reg   <= save_next;
        tmp_reg    <= tmp_next;
        first_reg  <= first_next;
        acc_reg    <= acc_next;
        found_reg  <= found_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        rev_i_reg  <= rev_i_next;
        rev_j_reg  <= rev_j_next;
        pairs_reg  <= pairs_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_value_reg  <= acc_wide[VALUE_W-1:0];
            out_found_reg  <= found_reg;
            out_len_reg    <= LEN_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_status_reg, out_len_reg, out_found_reg, out_value_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("memory write while idle");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status_reg == STAT_FULL) |-> (out_len_reg == LEN_W'(CAPACITY)))
        else $error("full status with list not at capacity");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_found_reg != '1) |-> (out_status_reg == STAT_OK))
        else $error("match reported with error status");

endmodule

`default_nettype wire

// File: sv/ale_div.sv
// ============================================================================
// ale_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ============================================================================
`default_nettype none

module ale_div #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_reg}) : DIVISOR_W'(trial);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ============================================================================
// tb_top: stream-level test of the array list engine
// Drives operation transactions into the list engine, predicts each result
// with a behavioral list model and compares every result field in order.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

    import ale_pkg::*;

    localparam int CAP         = 64;
    localparam int WATCH_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        status_t                   status;
        logic [LEN_W-1:0]          length;
        logic signed [INDEX_W-1:0] index;
        logic signed [VALUE_W-1:0] value;
    } list_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [WORD_W-1:0] list_words [CAP];
    int                list_len;
    list_result_t      pending_results [$];
    int                error_count;
    int                result_count;
    int                item_count;
    int                idle_cycles;
    bit                gaps_on;
    bit                hold_sink;
    bit                timed_out;

    array_list_engine #(.CAPACITY(CAP)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [VALUE_W-1:0] word_val(int i);
        return VALUE_W'($signed(list_words[i]));
    endfunction

    function automatic list_result_t apply_list_op(op_t op, int pos, logic [WORD_W-1:0] word);
        list_result_t r;
        logic signed [VALUE_W-1:0] acc;
        logic signed [VALUE_W-1:0] key;
        logic [WORD_W-1:0] t;
        int lo;
        int hi;
        int mid;
        int n;
        n = list_len;
        acc = '0;
        key = VALUE_W'($signed(word));
        r.index = '1;
        r.status = STAT_OK;
        if (n == 0 && op inside {OP_DELETE, OP_GET, OP_SET, OP_MAX, OP_MIN, OP_AVG})
            r.status = STAT_EMPTY;
        else if (op inside {OP_DELETE, OP_GET, OP_SET} && pos >= n)
            r.status = STAT_BAD_INDEX;
        else
        begin
            case (op)
                OP_INSERT:
                begin
                    if (n >= CAP)
                        r.status = STAT_FULL;
                    else
                    begin
                        if (pos > n)
                            pos = n;
                        for (int i = n; i > pos; i--)
                            list_words[i] = list_words[i-1];
                        list_words[pos] = word;
                        n++;
                    end
                end
                OP_DELETE:
                begin
                    for (int i = pos; i + 1 < n; i++)
                        list_words[i] = list_words[i+1];
                    n--;
                end
                OP_GET: acc = word_val(pos);
                OP_SET: list_words[pos] = word;
                OP_LSEARCH:
                begin
                    for (int i = 0; i < n; i++)
                        if (word_val(i) == key)
                        begin
                            r.index = INDEX_W'(i);
                            break;
                        end
                end
                OP_BSEARCH:
                begin
                    lo = 0;
                    hi = n - 1;
                    while (lo <= hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (word_val(mid) == key)
                        begin
                            r.index = INDEX_W'(mid);
                            break;
                        end
                        if (key > word_val(mid))
                            lo = mid + 1;
                        else
                            hi = mid - 1;
                    end
                end
                OP_MAX, OP_MIN:
                begin
                    acc = word_val(0);
                    for (int i = 1; i < n; i++)
                        if (op == OP_MAX ? word_val(i) > acc : word_val(i) < acc)
                            acc = word_val(i);
                end
                OP_SUM, OP_AVG:
                begin
                    for (int i = 0; i < n; i++)
                        acc += word_val(i);
                    if (op == OP_AVG)
                        acc = acc / VALUE_W'(n);
                end
                OP_REVERSE:
                begin
                    for (int i = 0; i < n / 2; i++)
                    begin
                        t = list_words[i];
                        list_words[i] = list_words[n-1-i];
                        list_words[n-1-i] = t;
                    end
                end
                OP_LSHIFT, OP_LROT:
                begin
                    if (n > 0)
                    begin
                        t = list_words[0];
                        for (int i = 0; i + 1 < n; i++)
                            list_words[i] = list_words[i+1];
                        list_words[n-1] = (op == OP_LROT) ? t : '0;
                    end
                end
                OP_RSHIFT, OP_RROT:
                begin
                    if (n > 0)
                    begin
                        t = list_words[n-1];
                        for (int i = n - 1; i > 0; i--)
                            list_words[i] = list_words[i-1];
                        list_words[0] = (op == OP_RROT) ? t : '0;
                    end
                end
                default: ;
            endcase
        end
        list_len = n;
        r.value = acc;
        r.length = LEN_W'(n);
        return r;
    endfunction

    task automatic send_op(op_t op, int pos, logic [WORD_W-1:0] word);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, word, 6'(pos), op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_list_op(op, pos, word));
        item_count++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return WORD_W'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            list_result_t got;
            list_result_t want;
            got = m_axis_tdata[53:0];
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                begin
                    $error("result_value expected %0d actual %0d", want.value, got.value);
                    error_count++;
                end
                if (got.index !== want.index)
                begin
                    $error("found_index expected %0d actual %0d", want.index, got.index);
                    error_count++;
                end
                if (got.length !== want.length)
                begin
                    $error("list_length expected %0d actual %0d", want.length, got.length);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_sink)
            m_axis_tready <= 1'b0;
        else if (gaps_on && m_axis_tready && $urandom_range(0, 4) == 0)
            m_axis_tready <= 1'b0;
        else if (!m_axis_tready && gaps_on && $urandom_range(0, 2) != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(OP_GET, 0, 0);
        send_op(OP_SUM, 0, 0);
        send_op(OP_AVG, 0, 0);
        send_op(OP_LSEARCH, 0, 5);
        send_op(OP_BSEARCH, 0, 5);
        send_op(OP_REVERSE, 0, 0);
        send_op(OP_LSHIFT, 0, 0);
        send_op(OP_RROT, 0, 0);
        send_op(OP_INSERT, 63, 32'h8000_0000);
        send_op(OP_INSERT, 0, 32'h7fff_ffff);
        send_op(OP_INSERT, 1, 32'hffff_fffd);
        send_op(OP_GET, 63, 0);
        send_op(OP_SET, 2, 32'h0000_0011);
        send_op(OP_MAX, 0, 0);
        send_op(OP_MIN, 0, 0);
        send_op(OP_AVG, 0, 0);
        send_op(OP_LSEARCH, 0, 32'h11);
        send_op(OP_BSEARCH, 0, 32'h7fff_ffff);
        send_op(OP_REVERSE, 0, 0);
        send_op(OP_LROT, 0, 0);
        send_op(OP_RSHIFT, 0, 0);
        send_op(OP_LSHIFT, 0, 0);
        send_op(OP_DELETE, 5, 0);
        send_op(OP_DELETE, 0, 0);
        send_op(OP_NOP, 0, 0);
        end_burst();
    endtask

    task automatic test_fill_and_stall();
        gaps_on = 1'b0;
        hold_sink = 1'b1;
        fork
            begin
                for (int i = 0; i < CAP + 3; i++)
                    send_op(OP_INSERT, $urandom_range(0, 63), rand_word());
                send_op(OP_SUM, 0, 0);
                send_op(OP_GET, 63, 0);
                end_burst();
            end
            begin
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
            end
        join
        send_op(OP_AVG, 0, 0);
        for (int i = 0; i < 20; i++)
            send_op(op_t'($urandom_range(1, 15)), $urandom_range(0, 63), rand_word());
        end_burst();
        gaps_on = 1'b1;
    endtask

    task automatic test_sorted_search();
        logic [WORD_W-1:0] w;
        while (list_len > 0)
            send_op(OP_DELETE, 0, 0);
        for (int k = 0; k < 5; k++)
        begin
            w = $urandom_range(0, 1000) - 500;
            for (int i = 0; i < $urandom_range(1, 20); i++)
            begin
                w = w + $urandom_range(0, 3);
                send_op(OP_INSERT, 63, w);
            end
            for (int i = 0; i < 8; i++)
                send_op(OP_BSEARCH, 0, w - $urandom_range(0, 40));
            while (list_len > 0)
                send_op(OP_DELETE, 0, 0);
        end
        end_burst();
    endtask

    task automatic test_random(int count);
        op_t op;
        int pos;
        for (int i = 0; i < count; i++)
        begin
            if (list_len < 6)
                op = ($urandom_range(0, 2) != 0) ? OP_INSERT : op_t'($urandom_range(0, 15));
            else if (list_len > 40)
                op = ($urandom_range(0, 2) == 0) ? OP_DELETE : op_t'($urandom_range(1, 15));
            else
                op = op_t'($urandom_range(0, 15));
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, list_len > 0 ? list_len : 0);
            if (pos > 63)
                pos = 63;
            send_op(op, pos, ($urandom_range(0, 2) == 0 && list_len > 0)
                    ? list_words[$urandom_range(0, list_len - 1)] : rand_word());
        end
        end_burst();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        list_len      = 0;
        error_count   = 0;
        result_count  = 0;
        item_count    = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        hold_sink     = 1'b0;
        timed_out     = 1'b0;
        foreach (list_words[i])
            list_words[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_stall();
        test_sorted_search();
        test_random(420);
        gaps_on = 1'b0;
        test_random(120);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Ran %0d operation transactions and checked %0d results,", item_count,
                 result_count);
        $display("with empty, full, bad index, sorted search and backpressure cases.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
